[rtl/core/yrpp_pkg.sv]
// Shared types and constants for the YUV to RGB converter and pixel packer.
`timescale 1ns / 1ps
`default_nettype none

package yrpp_pkg;

  // Pixel format codes; code three behaves as the bitfield layout.
  localparam logic [1:0] FMT_RGB565   = 2'd0;
  localparam logic [1:0] FMT_XRGB8888 = 2'd1;
  localparam logic [1:0] FMT_BITFIELD = 2'd2;
  localparam logic [1:0] FMT_SPARE    = 2'd3;

  // Widths of the configuration registers and of the write port.
  localparam int unsigned WIDTH_BITS = 4;
  localparam int unsigned POS_BITS   = 5;
  localparam int unsigned CFG_BITS   = 5;
  localparam int unsigned INDEX_BITS = 3;

  // Register indexes of the configuration port.
  localparam logic [INDEX_BITS-1:0] REG_FORMAT      = 3'd0;
  localparam logic [INDEX_BITS-1:0] REG_RED_WIDTH   = 3'd1;
  localparam logic [INDEX_BITS-1:0] REG_RED_POS     = 3'd2;
  localparam logic [INDEX_BITS-1:0] REG_GREEN_WIDTH = 3'd3;
  localparam logic [INDEX_BITS-1:0] REG_GREEN_POS   = 3'd4;
  localparam logic [INDEX_BITS-1:0] REG_BLUE_WIDTH  = 3'd5;
  localparam logic [INDEX_BITS-1:0] REG_BLUE_POS    = 3'd6;

  // Register values after reset.
  localparam logic [1:0]            RST_FORMAT    = FMT_XRGB8888;
  localparam logic [WIDTH_BITS-1:0] RST_WIDTH     = 4'd8;
  localparam logic [POS_BITS-1:0]   RST_RED_POS   = 5'd16;
  localparam logic [POS_BITS-1:0]   RST_GREEN_POS = 5'd8;
  localparam logic [POS_BITS-1:0]   RST_BLUE_POS  = 5'd0;

  // Input beat: one luma sample and the chroma pair it shares.
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } pixel_in_t;

  // Output beat: clamped channels and the packed display word.
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [31:0] pixel_word;
  } pixel_out_t;

  // Clamped channel values between converter and packer.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Packing controls held in the configuration registers.
  typedef struct packed {
    logic [1:0]            pixel_format;
    logic [WIDTH_BITS-1:0] red_width;
    logic [POS_BITS-1:0]   red_position;
    logic [WIDTH_BITS-1:0] green_width;
    logic [POS_BITS-1:0]   green_position;
    logic [WIDTH_BITS-1:0] blue_width;
    logic [POS_BITS-1:0]   blue_position;
  } pack_cfg_t;

endpackage

`default_nettype wire

[rtl/core/yuv_to_rgb_pixel_packer_core.sv]
// Top level: input register, conversion and packing, output register.
//
//   Channel  Direction  Handshake              Beat
//   in       input      in_valid / in_stall    pixel_in_t  (luma, chroma_blue, chroma_red)
//   out      output     out_valid / out_stall  pixel_out_t (red, green, blue, pixel_word)
//   cfg      input      cfg_write              cfg_index selects, cfg_data carries value
//
// One beat per clock sustained while out_stall is low; a beat passes through the input register
// and then the result register, with the conversion logic between them.
// Reset (rst, synchronous) empties both registers and loads the default XRGB8888
// layout. A stall on the output holds the result; the input keeps accepting until
// both registers are full.
`timescale 1ns / 1ps
`default_nettype none

module yuv_to_rgb_pixel_packer_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  yrpp_pkg::pixel_in_t                   in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output yrpp_pkg::pixel_out_t                  out_data,
  input  logic                                  cfg_write,
  input  logic [yrpp_pkg::INDEX_BITS-1:0]       cfg_index,
  input  logic [yrpp_pkg::CFG_BITS-1:0]         cfg_data
);

  yrpp_pkg::pack_cfg_t  cfg;
  yrpp_pkg::pixel_in_t  stage_data;
  logic                 stage_valid;
  logic                 stage_load;
  logic                 out_load;
  yrpp_pkg::rgb_t       rgb;
  logic [31:0]          pixel_word;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_format   <= yrpp_pkg::RST_FORMAT;
      cfg.red_width      <= yrpp_pkg::RST_WIDTH;
      cfg.red_position   <= yrpp_pkg::RST_RED_POS;
      cfg.green_width    <= yrpp_pkg::RST_WIDTH;
      cfg.green_position <= yrpp_pkg::RST_GREEN_POS;
      cfg.blue_width     <= yrpp_pkg::RST_WIDTH;
      cfg.blue_position  <= yrpp_pkg::RST_BLUE_POS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        yrpp_pkg::REG_FORMAT:      cfg.pixel_format   <= cfg_data[1:0];
        yrpp_pkg::REG_RED_WIDTH:   cfg.red_width      <= cfg_data[yrpp_pkg::WIDTH_BITS-1:0];
        yrpp_pkg::REG_RED_POS:     cfg.red_position   <= cfg_data[yrpp_pkg::POS_BITS-1:0];
        yrpp_pkg::REG_GREEN_WIDTH: cfg.green_width    <= cfg_data[yrpp_pkg::WIDTH_BITS-1:0];
        yrpp_pkg::REG_GREEN_POS:   cfg.green_position <= cfg_data[yrpp_pkg::POS_BITS-1:0];
        yrpp_pkg::REG_BLUE_WIDTH:  cfg.blue_width     <= cfg_data[yrpp_pkg::WIDTH_BITS-1:0];
        yrpp_pkg::REG_BLUE_POS:    cfg.blue_position  <= cfg_data[yrpp_pkg::POS_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Flow control: each register loads when it is empty or drains this cycle.
  assign out_load   = !out_valid || !out_stall;
  assign stage_load = !stage_valid || out_load;
  assign in_stall   = !stage_load;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stage_load) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_load && in_valid) begin
      stage_data <= in_data;
    end
  end

  // Conversion and packing between the two registers.
  yrpp_convert u_convert (
    .pixel (stage_data),
    .rgb   (rgb)
  );

  yrpp_pack u_pack (
    .rgb        (rgb),
    .cfg        (cfg),
    .pixel_word (pixel_word)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && stage_valid) begin
      out_data.red        <= rgb.red;
      out_data.green      <= rgb.green;
      out_data.blue       <= rgb.blue;
      out_data.pixel_word <= pixel_word;
    end
  end

endmodule

`default_nettype wire

[rtl/core/yrpp_convert.sv]
// BT.601 limited-range YUV to RGB conversion with clamping to 0..255.
`timescale 1ns / 1ps
`default_nettype none

module yrpp_convert (
  input  yrpp_pkg::pixel_in_t pixel,
  output yrpp_pkg::rgb_t      rgb
);

  // Coefficients scaled by 256, rounding offset and black level.
  localparam logic signed [18:0] COEF_Y     = 19'sd298;
  localparam logic signed [18:0] COEF_RV    = 19'sd409;
  localparam logic signed [18:0] COEF_GU    = 19'sd100;
  localparam logic signed [18:0] COEF_GV    = 19'sd208;
  localparam logic signed [18:0] COEF_BU    = 19'sd516;
  localparam logic signed [18:0] ROUND_HALF = 19'sd128;
  localparam logic [7:0]         BLACK      = 8'd16;
  localparam logic signed [8:0]  CHROMA_MID = 9'sd128;

  logic [7:0]         luma_off;
  logic signed [8:0]  d9;
  logic signed [8:0]  e9;
  logic signed [18:0] c19;
  logic signed [18:0] d19;
  logic signed [18:0] e19;
  logic signed [18:0] y_term;
  logic signed [18:0] red_sum;
  logic signed [18:0] green_sum;
  logic signed [18:0] blue_sum;

  // Clamp floor(sum / 256) into a byte; the shift is a plain bit-select.
  function automatic logic [7:0] scale_clamp(input logic signed [18:0] sum);
    logic [10:0] q;
    begin
      q = sum[18:8];
      if (q[10]) begin
        scale_clamp = 8'd0;
      end else if (q[9:8] != 2'b00) begin
        scale_clamp = 8'd255;
      end else begin
        scale_clamp = q[7:0];
      end
    end
  endfunction

  // Luma below the black level floors at zero; chroma is centered.
  always_comb begin
    luma_off = (pixel.luma < BLACK) ? 8'd0 : (pixel.luma - BLACK);
    d9       = $signed({1'b0, pixel.chroma_blue}) - CHROMA_MID;
    e9       = $signed({1'b0, pixel.chroma_red}) - CHROMA_MID;
    c19      = $signed({11'd0, luma_off});
    d19      = {{10{d9[8]}}, d9};
    e19      = {{10{e9[8]}}, e9};
  end

  // Channel sums, then scale and clamp.
  always_comb begin
    y_term    = COEF_Y * c19 + ROUND_HALF;
    red_sum   = y_term + COEF_RV * e19;
    green_sum = y_term - COEF_GU * d19 - COEF_GV * e19;
    blue_sum  = y_term + COEF_BU * d19;
    rgb.red   = scale_clamp(red_sum);
    rgb.green = scale_clamp(green_sum);
    rgb.blue  = scale_clamp(blue_sum);
  end

endmodule

`default_nettype wire

[rtl/core/yrpp_pack.sv]
// Packs three 8-bit channels into a 32-bit display word.
`timescale 1ns / 1ps
`default_nettype none

module yrpp_pack (
  input  yrpp_pkg::rgb_t      rgb,
  input  yrpp_pkg::pack_cfg_t cfg,
  output logic [31:0]         pixel_word
);

  logic [31:0] red_field;
  logic [31:0] green_field;
  logic [31:0] blue_field;

  // Keep the top bits of a channel and shift them to their offset.
  // A zero width drops the channel; widths above eight keep all of it.
  function automatic logic [31:0] place_field(
    input logic [7:0]                        chan,
    input logic [yrpp_pkg::WIDTH_BITS-1:0]   width,
    input logic [yrpp_pkg::POS_BITS-1:0]     pos
  );
    logic [3:0]  drop;
    logic [31:0] kept;
    begin
      drop = (width > 4'd8) ? 4'd0 : (4'd8 - width);
      kept = {24'd0, chan >> drop};
      if (width == 4'd0) begin
        place_field = 32'd0;
      end else begin
        place_field = kept << pos;
      end
    end
  endfunction

  always_comb begin
    red_field   = place_field(rgb.red, cfg.red_width, cfg.red_position);
    green_field = place_field(rgb.green, cfg.green_width, cfg.green_position);
    blue_field  = place_field(rgb.blue, cfg.blue_width, cfg.blue_position);
  end

  // Format select; overlapping bitfields are ORed together.
  always_comb begin
    case (cfg.pixel_format)
      yrpp_pkg::FMT_RGB565: begin
        pixel_word = {16'd0, rgb.red[7:3], rgb.green[7:2], rgb.blue[7:3]};
      end
      yrpp_pkg::FMT_XRGB8888: begin
        pixel_word = {8'd0, rgb.red, rgb.green, rgb.blue};
      end
      default: begin
        pixel_word = red_field | green_field | blue_field;
      end
    endcase
  end

endmodule

`default_nettype wire
